// ===== rtl/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 decoder.
// Holds the decode state and result types and the byte masks.
// No dependencies.
package u8u16_pkg;

  localparam logic [7:0]  ASCII_BIT  = 8'h80;
  localparam logic [7:0]  LEAD2_MASK = 8'h1F;
  localparam logic [7:0]  CONT_MASK  = 8'h3F;
  localparam logic [7:0]  LEAD3_MASK = 8'h0F;
  localparam logic [15:0] UNIT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  bytes_left;
    logic        skipping;
    logic [15:0] partial_value;
    logic [15:0] units_so_far;
  } state_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_done;
    logic [15:0] unit_count;
  } result_t;

endpackage

// ===== rtl/u8u16_if.sv =====
// Channel interfaces for the UTF-8 to UTF-16 decoder.
// Byte input channel and code unit output channel, valid/ready handshake.
// No dependencies.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        string_done;
  logic [15:0] unit_count;

  modport source (output valid, output code_unit, output unit_valid, output string_done,
                  output unit_count, input ready);
  modport sink (input valid, input code_unit, input unit_valid, input string_done,
                input unit_count, output ready);
endinterface

// ===== rtl/u8u16_decode.sv =====
// Combinational decode of one byte against the current sequence state.
// Gives the next state, the result and whether a result is produced.
// Depends on u8u16_pkg.
module u8u16_decode (
  input  u8u16_pkg::state_t  st,
  input  logic [7:0]         in_byte,
  input  logic               last,
  output u8u16_pkg::state_t  st_next,
  output u8u16_pkg::result_t res,
  output logic               emit
);
  import u8u16_pkg::*;

  logic        have;
  logic [15:0] unit;
  logic [15:0] units;
  logic [15:0] cont;
  logic [7:0]  lead2_bits;
  logic [7:0]  lead3_bits;

  assign cont       = {8'b0, in_byte & CONT_MASK};
  assign lead2_bits = in_byte & LEAD2_MASK;
  assign lead3_bits = in_byte & LEAD3_MASK;

  always_comb begin
    st_next = st;
    have    = 1'b0;
    unit    = 16'b0;
    if (st.bytes_left != 3'd0) begin
      if (!st.skipping) begin
        case (st.bytes_left)
          3'd2:    st_next.partial_value = st.partial_value | (cont << 6);
          3'd1:    st_next.partial_value = st.partial_value | cont;
          default: st_next.partial_value = st.partial_value;
        endcase
      end
      st_next.bytes_left = st.bytes_left - 3'd1;
      if (st_next.bytes_left == 3'd0) begin
        if (!st.skipping) begin
          have = 1'b1;
          unit = st_next.partial_value;
        end
        st_next.skipping = 1'b0;
      end
    end else if ((in_byte & ASCII_BIT) == 8'b0) begin
      have = 1'b1;
      unit = {8'b0, in_byte};
    end else begin
      case (in_byte) inside
        8'b110?????: begin
          st_next.partial_value = {2'b0, lead2_bits, 6'b0};
          st_next.bytes_left    = 3'd1;
          st_next.skipping      = 1'b0;
        end
        8'b1110????: begin
          st_next.partial_value = {lead3_bits[3:0], 12'b0};
          st_next.bytes_left    = 3'd2;
          st_next.skipping      = 1'b0;
        end
        8'b11110???: begin
          st_next.partial_value = 16'b0;
          st_next.bytes_left    = 3'd3;
          st_next.skipping      = 1'b1;
        end
        8'b111110??: begin
          st_next.partial_value = 16'b0;
          st_next.bytes_left    = 3'd4;
          st_next.skipping      = 1'b1;
        end
        8'b1111110?: begin
          st_next.partial_value = 16'b0;
          st_next.bytes_left    = 3'd5;
          st_next.skipping      = 1'b1;
        end
        8'b11111110: begin
          st_next.partial_value = 16'b0;
          st_next.bytes_left    = 3'd6;
          st_next.skipping      = 1'b1;
        end
        8'b11111111: begin
          st_next.partial_value = 16'b0;
          st_next.bytes_left    = 3'd7;
          st_next.skipping      = 1'b1;
        end
        default: begin
          st_next = st;
        end
      endcase
    end

    // A sequence that is not being skipped and is left open at the end of the string is closed with zero bits.
    if (last && !have && (st_next.bytes_left != 3'd0) && !st_next.skipping) begin
      have = 1'b1;
      unit = st_next.partial_value;
    end

    units = st.units_so_far;
    if (have && (units != UNIT_MAX)) begin
      units = units + 16'd1;
    end
    st_next.units_so_far = units;

    emit            = last || have;
    res.code_unit   = have ? unit : 16'b0;
    res.unit_valid  = have;
    res.string_done = last;
    res.unit_count  = last ? units : 16'b0;

    if (last) begin
      st_next = '0;
    end
  end

endmodule

// ===== rtl/u8u16_out_reg.sv =====
// Result register for the decoder output channel.
// Holds one result until the downstream side takes the transaction.
// Depends on u8u16_pkg and u8u16_if.
module u8u16_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                emit,
  input  u8u16_pkg::result_t  res,
  output logic                free,
  u8u16_unit_if.source        units
);
  import u8u16_pkg::*;

  logic    valid;
  result_t held;

  assign free = !valid || units.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= emit;
    end else if (units.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      held <= res;
    end
  end

  assign units.valid       = valid;
  assign units.code_unit   = held.code_unit;
  assign units.unit_valid  = held.unit_valid;
  assign units.string_done = held.string_done;
  assign units.unit_count  = held.unit_count;

endmodule

// ===== rtl/utf8_to_utf16_decoder.sv =====
// Top level of the UTF-8 to UTF-16 decoder.
// Input register, sequence state, decode logic and result register.
// Depends on u8u16_pkg, u8u16_if, u8u16_decode and u8u16_out_reg.
//
//   Channel  Direction  Transaction
//   bytes    in         in_byte, end_of_string
//   units    out        code_unit, unit_valid, string_done, unit_count
//
// One byte is accepted every cycle unless units stalls; a byte passes the input register, then the result register.
// The sequence state is updated when the input register hands a byte to the
// result register, so the only loop is decode logic around the state register.
// A stall on units holds the result register and the input register in turn.
// Synchronous reset clears the state, count and both valid flags.
module utf8_to_utf16_decoder (
  input logic          clk,
  input logic          rst,
  u8u16_byte_if.sink   bytes,
  u8u16_unit_if.source units
);
  import u8u16_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       free;
  logic       emit;
  state_t     st;
  state_t     st_next;
  result_t    res;

  assign advance     = in_valid && free;
  assign bytes.ready = !in_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.in_byte;
      in_last <= bytes.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  u8u16_decode u_decode (
    .st      (st),
    .in_byte (in_byte),
    .last    (in_last),
    .st_next (st_next),
    .res     (res),
    .emit    (emit)
  );

  u8u16_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .emit    (emit),
    .res     (res),
    .free    (free),
    .units   (units)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for utf8_to_utf16_decoder: random and directed UTF-8 byte strings
// checked against a scoreboard that predicts every 16-bit code unit transaction.
// Depends on u8u16_pkg, u8u16_if and the decoder RTL.
module testbench;
  import u8u16_pkg::*;

  localparam int MAX_IDLE = 17;
  localparam int RANDOM_BYTES = 1250;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 1000;

  class utf16_unit_scoreboard;
    result_t expected_units[$];
    bit [2:0] seq_left;
    bit seq_skip;
    bit [15:0] seq_bits;
    bit [15:0] string_units;
    int mismatches;

    function void note_byte(logic [7:0] b, logic last);
      bit have;
      bit [15:0] unit;
      int ones;
      int sh;
      result_t r;
      have = 1'b0;
      unit = 16'h0000;
      if (seq_left != 0) begin
        if (!seq_skip) begin
          sh = 6 * (int'(seq_left) - 1);
          seq_bits = seq_bits | (16'(b & CONT_MASK) << sh);
        end
        seq_left = seq_left - 3'd1;
        if (seq_left == 0) begin
          if (!seq_skip) begin
            have = 1'b1;
            unit = seq_bits;
          end
          seq_skip = 1'b0;
        end
      end else if ((b & ASCII_BIT) == 8'h00) begin
        have = 1'b1;
        unit = {8'h00, b};
      end else begin
        ones = 0;
        while (ones < 8 && b[7 - ones]) ones++;
        if (ones == 2) begin
          seq_bits = {5'b0, b[4:0], 6'b0};
          seq_left = 3'd1;
          seq_skip = 1'b0;
        end else if (ones == 3) begin
          seq_bits = {b[3:0], 12'h000};
          seq_left = 3'd2;
          seq_skip = 1'b0;
        end else if (ones >= 4) begin
          seq_bits = 16'h0000;
          seq_left = 3'(ones - 1);
          seq_skip = 1'b1;
        end
      end
      if (last && !have && seq_left != 0 && !seq_skip) begin
        have = 1'b1;
        unit = seq_bits;
      end
      if (have && string_units != UNIT_MAX) string_units++;
      if (last || have) begin
        r.code_unit = have ? unit : 16'h0000;
        r.unit_valid = have;
        r.string_done = last;
        r.unit_count = last ? string_units : 16'h0000;
        expected_units.push_back(r);
      end
      if (last) begin
        seq_left = 3'd0;
        seq_skip = 1'b0;
        seq_bits = 16'h0000;
        string_units = 16'h0000;
      end
    endfunction

    function void check_unit(result_t got);
      result_t exp;
      bit bad;
      if (expected_units.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected unit %h valid %b done %b count %h", $realtime,
                   got.code_unit, got.unit_valid, got.string_done, got.unit_count);
        return;
      end
      exp = expected_units.pop_front();
      bad = 1'b0;
      if (got.code_unit !== exp.code_unit) bad = 1'b1;
      if (got.unit_valid !== exp.unit_valid) bad = 1'b1;
      if (got.string_done !== exp.string_done) bad = 1'b1;
      if (got.unit_count !== exp.unit_count) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected unit %h valid %b done %b count %h, got %h %b %b %h",
                   $realtime, exp.code_unit, exp.unit_valid, exp.string_done,
                   exp.unit_count, got.code_unit, got.unit_valid, got.string_done,
                   got.unit_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  u8u16_byte_if bytes_ch ();
  u8u16_unit_if units_ch ();

  utf16_unit_scoreboard sb;
  int sender_max_gap;
  int receiver_max_stall;
  bit hold_units;
  int idle_cycles;

  logic [8:0] opening_bytes [26] = '{
    9'h000, 9'h07F, 9'h080, 9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0C3, 9'h041,
    9'h0F0, 9'h011, 9'h022, 9'h033, 9'h0FF, 9'h001, 9'h002, 9'h003, 9'h004, 9'h005,
    9'h006, 9'h107, 9'h0E4, 9'h1B8, 9'h0F8, 9'h100
  };

  utf8_to_utf16_decoder u_dut (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_ch),
    .units(units_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((bytes_ch.valid && bytes_ch.ready) || (units_ch.valid && units_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, sender_max_gap);
    if (gap > 0) begin
      bytes_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bytes_ch.valid <= 1'b1;
    bytes_ch.in_byte <= b;
    bytes_ch.end_of_string <= last;
    do @(posedge clk); while (!bytes_ch.ready);
    sb.note_byte(b, last);
  endtask

  task automatic wait_for_drain();
    bytes_ch.valid <= 1'b0;
    while (sb.expected_units.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int stall;
    result_t got;
    units_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_units) begin
        stall = LONG_HOLD;
        hold_units = 1'b0;
      end else begin
        stall = $urandom_range(0, receiver_max_stall);
      end
      if (stall > 0) begin
        units_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      units_ch.ready <= 1'b1;
      do @(posedge clk); while (!units_ch.valid);
      got.code_unit = units_ch.code_unit;
      got.unit_valid = units_ch.unit_valid;
      got.string_done = units_ch.string_done;
      got.unit_count = units_ch.unit_count;
      sb.check_unit(got);
    end
  end

  initial begin
    int k;
    int n;
    int target;
    int random_sent;
    bit held;
    bit paused;
    logic [7:0] lead;
    logic [7:0] seq[$];
    sb = new();
    sender_max_gap = MAX_IDLE;
    receiver_max_stall = MAX_IDLE;
    hold_units = 1'b0;
    idle_cycles = 0;
    rst <= 1'b1;
    bytes_ch.valid <= 1'b0;
    bytes_ch.in_byte <= 8'h00;
    bytes_ch.end_of_string <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_bytes[i]) send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
    wait_for_drain();

    random_sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (random_sent < RANDOM_BYTES) begin
      if (!held && random_sent > 400) begin
        held = 1'b1;
        hold_units = 1'b1;
        sender_max_gap = 0;
        for (k = 0; k < 40; k++) send_byte(8'($urandom_range(0, 127)), k == 39);
      end
      if (!paused && random_sent > 800) begin
        paused = 1'b1;
        wait_for_drain();
      end
      if ($urandom_range(0, 3) == 0) begin
        sender_max_gap = 0;
        receiver_max_stall = 0;
      end else begin
        sender_max_gap = MAX_IDLE;
        receiver_max_stall = MAX_IDLE;
      end
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 16);
      seq.delete();
      while (seq.size() < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2: seq.push_back(8'($urandom_range(0, 127)));
          3, 4: begin
            seq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
          end
          5, 6: begin
            seq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
            seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
          end
          7: seq.push_back(8'($urandom_range(0, 255)));
          8: begin
            n = $urandom_range(4, 8);
            lead = (8'hFF << (8 - n)) | (8'($urandom) & (8'hFF >> (n + 1)));
            seq.push_back(lead);
            for (k = 1; k < n; k++) seq.push_back(8'($urandom_range(0, 255)));
          end
          default: begin
            seq.push_back(8'hC0 | 8'($urandom_range(0, 47)));
            seq.push_back(8'($urandom_range(0, 127)));
          end
        endcase
      end
      for (k = 0; k < target; k++) send_byte(seq[k], k == target - 1);
      random_sent += target;
    end

    wait_for_drain();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
